FILE: rtl/b2b_pkg.sv
package b2b_pkg;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

  localparam int ROUNDS = 12;
  localparam logic [0:0] REG_DIGEST = 1'b0;
  localparam logic [0:0] REG_KEY    = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic restart;    // reinitialise chain, counter, buffer count
    logic store;      // write word into buffer
    logic flush;      // counter += 128, buffer count = 0; sent with init
    logic fin;        // counter += tail, final flag
    logic init;       // load v from chain
    logic half;       // run one half round (column or diagonal)
    logic feed;       // xor v into chain
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;       // sixteen words buffered
    logic [2:0] nout_m1;
  } dp_stat_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

FILE: rtl/blake2b_hash_unit.sv
// BLAKE2b hash unit, 12 rounds.
// Input stream s_axis: tdata[63:0] = msg_word (first byte low), tuser[3:0] =
// byte_count, tlast = last word of the message. Output stream m_axis:
// tdata[63:0] = digest_word, tuser[2:0] = word_index, tlast on the final word.
// Config: cfg_we/cfg_addr/cfg_wdata; index 0 digest_bytes, 1 key_bytes. Any
// write restarts the hash state.
// Non-final words are taken back to back until a full block is buffered; the
// next data word is then held off while the block is flushed, run through 24
// half rounds and fed into the chain. Once the last word is accepted, the
// final block is compressed (after any full block that must be flushed first),
// then ceil(n/8) output words follow, n being digest_bytes clamped to 1..64,
// one per cycle while m_axis_tready is high. A stalled receiver holds the
// output word; no input is taken until all digest words are delivered. The
// compression unit (one half round, four G functions per cycle) sets the rate.
// Reset: digest 64 bytes, unkeyed, empty message state.
module blake2b_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // msg_word
  input  logic [3:0]  s_axis_tuser,   // byte_count
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast
);
  import b2b_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  dp_cmd_t  dcmd;

  // a config write restarts the datapath state too
  always_comb begin
    dcmd = cmd;
    if (cfg_we) begin
      dcmd = '0;
      dcmd.restart = 1'b1;
    end
  end

  b2b_control u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we),
    .in_valid(s_axis_tvalid), .in_bc(s_axis_tuser), .in_last(s_axis_tlast),
    .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_idx(m_axis_tuser), .out_last(m_axis_tlast),
    .cmd(cmd), .stat(stat)
  );

  b2b_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(dcmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_sel(cfg_addr), .cfg_data(cfg_wdata),
    .word(s_axis_tdata), .bc(s_axis_tuser), .out_idx(m_axis_tuser),
    .out_word(m_axis_tdata)
  );
endmodule

FILE: rtl/b2b_datapath.sv
module b2b_datapath (
  input  logic              clk,
  input  logic              rst,
  input  b2b_pkg::dp_cmd_t  cmd,
  output b2b_pkg::dp_stat_t stat,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_sel,
  input  logic [6:0]        cfg_data,
  input  logic [63:0]       word,
  input  logic [3:0]        bc,
  input  logic [2:0]        out_idx,
  output logic [63:0]       out_word
);
  import b2b_pkg::*;

  logic [6:0]  digest_bytes, key_bytes;
  logic [6:0]  digest_next, key_next;
  logic [63:0] chain [8];
  logic [63:0] cnt_lo, cnt_hi;
  logic [63:0] buffer [16];
  logic [4:0]  nbuf;
  logic [63:0] v [16];
  logic [3:0]  round;
  logic        diag;

  logic [6:0]  dig_eff, key_eff;
  logic [3:0]  bc_sat;
  logic [63:0] wmask;
  logic [63:0] p0;
  logic [63:0] tail, add_n, lo_sum, hi_sum;
  logic [3:0]  srow;
  logic [63:0] vn [16];

  // parameter block follows a register write in the same cycle
  assign digest_next = (cfg_we && cfg_sel == REG_DIGEST) ? cfg_data : digest_bytes;
  assign key_next = (cfg_we && cfg_sel == REG_KEY) ? cfg_data : key_bytes;

  assign dig_eff = (digest_next == 7'd0) ? 7'd1 :
                   (digest_next > 7'd64) ? 7'd64 : digest_next;
  assign key_eff = (key_next > 7'd64) ? 7'd64 : key_next;
  assign p0 = {32'd0, 8'd1, 8'd1, 1'b0, key_eff, 1'b0, dig_eff};
  assign stat.full = nbuf[4];
  assign stat.nout_m1 = 3'((dig_eff - 7'd1) >> 3);

  assign bc_sat = (bc > 4'd8) ? 4'd8 : bc;
  always_comb begin
    wmask = '1;
    if (cmd.fin && bc_sat < 4'd8) wmask = (64'd1 << {bc_sat[2:0], 3'b000}) - 64'd1;
  end

  // buffer count after store on the final word is nbuf+store
  assign tail = {56'd0, nbuf, 3'b000} + ((bc_sat != 4'd0) ? {60'd0, bc_sat} : 64'd0);
  assign add_n = cmd.flush ? 64'd128 : tail;
  assign lo_sum = cnt_lo + add_n;
  assign hi_sum = cnt_hi + {63'd0, (lo_sum < add_n)};
  assign out_word = chain[out_idx];
  assign srow = (round >= 4'd10) ? round - 4'd10 : round;

  function automatic void gmix(inout logic [63:0] a, b, c, d,
                               input logic [63:0] x, y);
    a = a + b + x; d = rotr(d ^ a, 32);
    c = c + d;     b = rotr(b ^ c, 24);
    a = a + b + y; d = rotr(d ^ a, 16);
    c = c + d;     b = rotr(b ^ c, 63);
  endfunction

  always_comb begin
    logic [63:0] t [16];
    for (int i = 0; i < 16; i++) t[i] = v[i];
    if (!diag) begin
      for (int j = 0; j < 4; j++)
        gmix(t[j], t[j+4], t[j+8], t[j+12],
             buffer[SIGMA[srow][2*j]], buffer[SIGMA[srow][2*j+1]]);
    end else begin
      for (int j = 0; j < 4; j++)
        gmix(t[j], t[4+((j+1)%4)], t[8+((j+2)%4)], t[12+((j+3)%4)],
             buffer[SIGMA[srow][8+2*j]], buffer[SIGMA[srow][9+2*j]]);
    end
    for (int i = 0; i < 16; i++) vn[i] = t[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_bytes <= 7'd64;
      key_bytes <= 7'd0;
    end else begin
      digest_bytes <= digest_next;
      key_bytes <= key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
      chain[0] <= IV[0] ^ p0;
      cnt_lo <= '0;
      cnt_hi <= '0;
      nbuf <= '0;
      round <= '0;
      diag <= 1'b0;
    end else begin
      if (cmd.flush || cmd.fin) begin
        cnt_lo <= lo_sum;
        cnt_hi <= hi_sum;
      end
      if (cmd.flush) nbuf <= '0;
      else if (cmd.store) nbuf <= nbuf + 5'd1;
      // init always comes with flush or fin, so v takes the advanced counter
      if (cmd.init) begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= chain[i];
          v[i+8] <= IV[i];
        end
        v[12] <= IV[4] ^ lo_sum;
        v[13] <= IV[5] ^ hi_sum;
        v[14] <= cmd.fin ? ~IV[6] : IV[6];
        round <= '0;
        diag <= 1'b0;
      end else if (cmd.half) begin
        for (int i = 0; i < 16; i++) v[i] <= vn[i];
        diag <= ~diag;
        if (diag) round <= round + 4'd1;
      end
      if (cmd.feed)
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] ^ v[i] ^ v[i+8];
    end
  end

  // padding clears the tail of the buffer on the final block
  always_ff @(posedge clk) begin
    if (cmd.store) buffer[nbuf[3:0]] <= word & wmask;
    if (cmd.fin)
      for (int i = 0; i < 16; i++)
        if (5'(i) > nbuf || (5'(i) == nbuf && bc_sat == 4'd0)) buffer[i] <= '0;
  end
endmodule

FILE: rtl/b2b_control.sv
module b2b_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              in_valid,
  input  logic [3:0]        in_bc,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_idx,
  output logic              out_last,
  output b2b_pkg::dp_cmd_t  cmd,
  input  b2b_pkg::dp_stat_t stat
);
  import b2b_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd3, S_FEED = 3'd4, S_OUT = 3'd5;

  logic [2:0] state, state_next;
  logic       fin, fin_next;
  logic [4:0] halves;
  logic [2:0] idx;
  logic       need_flush;

  // a data word on a full buffer waits while the buffered block is compressed
  assign need_flush = (in_bc != 4'd0) && stat.full;
  assign in_ready = (state == S_IDLE) && !cfg_we && !need_flush;
  assign out_valid = (state == S_OUT);
  assign out_idx = idx;
  assign out_last = (idx == stat.nout_m1);

  logic acc;
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    fin_next = fin;
    unique case (state)
      S_IDLE: if (in_valid && !cfg_we && need_flush) begin
        cmd.flush = 1'b1; cmd.init = 1'b1;
        fin_next = 1'b0;
        state_next = S_RUN;
      end else if (acc) begin
        if (in_last) begin
          cmd.store = (in_bc != 4'd0);
          cmd.fin = 1'b1; cmd.init = 1'b1;
          fin_next = 1'b1;
          state_next = S_RUN;
        end else if (in_bc != 4'd0) begin
          cmd.store = 1'b1;
        end
      end
      S_RUN: begin
        cmd.half = 1'b1;
        if (halves == 5'(2*ROUNDS-1)) state_next = S_FEED;
      end
      S_FEED: begin
        cmd.feed = 1'b1;
        state_next = fin ? S_OUT : S_IDLE;
      end
      S_OUT: if (out_ready && out_last) begin
        cmd.restart = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_IDLE;
      fin <= 1'b0;
      halves <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      fin <= fin_next;
      if (state == S_RUN) halves <= halves + 5'd1;
      else halves <= '0;
      if (state == S_OUT && out_ready) idx <= out_last ? 3'd0 : idx + 3'd1;
    end
  end

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_FEED) |-> $past(halves) == 5'(2*ROUNDS-1))
    else $error("round count slip");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("accept while busy");
  a_out_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx <= stat.nout_m1)
    else $error("digest index past end");
endmodule

FILE: bench/blake2b_checker.sv
`timescale 1ns / 100ps

module blake2b_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // msg_word
  input  logic [3:0]  s_axis_tuser,   // byte_count
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // digest_word
  input  logic [2:0]  m_axis_tuser,   // word_index
  input  logic        m_axis_tlast,
  output int          errors,
  output int          pending
);
  import b2b_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_word_t;

  localparam logic [63:0] INIT_VEC [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam int MSG_ORDER [10][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
    '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
    '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
    '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
    '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
    '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
    '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
    '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

  // column then diagonal G lanes: a, b, c, d
  localparam int LANE [8][4] = '{
    '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
    '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}};

  logic [6:0]   digest_reg, key_reg;
  logic [63:0]  chain [8];
  logic [127:0] bytes_done;
  logic [63:0]  block [16];
  int           held;
  digest_word_t digest_q [$];

  assign pending = digest_q.size();

  function automatic int digest_len();
    if (digest_reg == 0) return 1;
    if (digest_reg > 64) return 64;
    return digest_reg;
  endfunction

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic reinit();
    logic [63:0] pblk;
    pblk = 64'(digest_len()) | (64'(key_reg > 64 ? 7'd64 : key_reg) << 8) |
           (64'd1 << 16) | (64'd1 << 24);
    for (int i = 0; i < 8; i++) chain[i] = INIT_VEC[i];
    chain[0] ^= pblk;
    bytes_done = '0;
    for (int i = 0; i < 16; i++) block[i] = '0;
    held = 0;
  endtask

  task automatic compress(bit final_blk);
    logic [63:0] v [16];
    int a, b, c, d;
    for (int i = 0; i < 8; i++) begin
      v[i] = chain[i];
      v[i+8] = INIT_VEC[i];
    end
    v[12] ^= bytes_done[63:0];
    v[13] ^= bytes_done[127:64];
    if (final_blk) v[14] = ~v[14];
    for (int r = 0; r < 12; r++) begin
      for (int g = 0; g < 8; g++) begin
        a = LANE[g][0]; b = LANE[g][1]; c = LANE[g][2]; d = LANE[g][3];
        v[a] = v[a] + v[b] + block[MSG_ORDER[r % 10][2*g]];
        v[d] = ror(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + block[MSG_ORDER[r % 10][2*g+1]];
        v[d] = ror(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 63);
      end
    end
    for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
  endtask

  task automatic take_word(logic [63:0] data, logic [3:0] count, logic fin);
    int bc, nwords;
    logic [127:0] tail;
    digest_word_t dw;
    bc = count > 8 ? 8 : count;
    if (!fin && bc == 0) return;
    if (bc > 0) begin
      if (held >= 16) begin
        bytes_done += 128;
        compress(0);
        held = 0;
      end
      if (fin && bc < 8) data &= (64'd1 << (8 * bc)) - 1;
      block[held] = data;
      held++;
    end
    if (!fin) return;
    tail = bc > 0 ? 128'((held - 1) * 8 + bc) : 128'(held * 8);
    for (int i = held; i < 16; i++) block[i] = '0;
    bytes_done += tail;
    compress(1);
    nwords = (digest_len() + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      dw.word = chain[k];
      dw.index = 3'(k);
      dw.final_word = (k + 1 == nwords);
      digest_q.push_back(dw);
    end
    reinit();
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: digest mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    digest_word_t dw;
    if (rst) begin
      digest_reg = 7'd64;
      key_reg = 7'd0;
      reinit();
      digest_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_DIGEST) digest_reg = cfg_wdata;
        else key_reg = cfg_wdata;
        reinit();
      end
      if (s_axis_tvalid && s_axis_tready)
        take_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest word %h with no request pending", $realtime, m_axis_tdata);
          errors++;
        end else begin
          dw = digest_q.pop_front();
          if (m_axis_tdata !== dw.word) report("word", m_axis_tdata, dw.word);
          if (m_axis_tuser !== dw.index) report("index", 64'(m_axis_tuser), 64'(dw.index));
          if (m_axis_tlast !== dw.final_word)
            report("last", 64'(m_axis_tlast), 64'(dw.final_word));
        end
      end
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import b2b_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 40;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [0:0]  cfg_addr = REG_DIGEST;
  logic [6:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // msg_word
  logic [3:0]  s_axis_tuser = '0;   // byte_count
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;        // digest_word
  logic [2:0]  m_axis_tuser;        // word_index
  logic        m_axis_tlast;

  int  errors, pending;
  int  burst_left = 0;
  int  sent = 0;
  int  idle_cycles = 0;
  bit  hold_off = 0;

  always #4 clk = ~clk;

  blake2b_hash_unit i_dut (.*);

  blake2b_checker i_checker (.*);

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles <= 0;
    else if (!rst)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: changes stall pattern every so often, long hold-off on request
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        if (hold_off) begin
          m_axis_tready <= 0;
          repeat (300) @(negedge clk);
          hold_off = 0;
        end
        case (mode)
          0: m_axis_tready <= 1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_word(logic [63:0] data, logic [3:0] count, logic fin);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        s_axis_tvalid <= 0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= data;
    s_axis_tuser <= count;
    s_axis_tlast <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    drain();
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // one message; keyed runs lead with the 16-word key block
  task automatic send_message(bit keyed, int nwords);
    int r;
    if (keyed)
      for (int i = 0; i < 16; i++) send_word(rand_word(), 4'd8, 0);
    for (int i = 0; i < nwords; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_word(rand_word(), 4'd0, 0);
      else if (r == 1) send_word(rand_word(), 4'($urandom_range(1, 7)), 0);
      else if (r == 2) send_word(rand_word(), 4'($urandom_range(9, 15)), 0);
      else send_word(rand_word(), 4'd8, 0);
    end
    send_word(rand_word(), 4'($urandom_range(0, 15)), 1);
  endtask

  initial begin
    logic [6:0] dig_set [6];
    logic [6:0] key_set [6];
    int start;
    dig_set = '{7'd64, 7'd1, 7'd0, 7'd127, 7'($urandom_range(2, 63)), 7'($urandom())};
    key_set = '{7'd0, 7'd64, 7'd127, 7'd0, 7'($urandom_range(1, 63)), 7'($urandom())};

    repeat (11) @(negedge clk);
    rst <= 0;

    // directed: empty message, all-ones word, odd byte counts, full block
    send_word(64'd0, 4'd0, 1);
    send_word('1, 4'd8, 1);
    send_word('1, 4'd0, 0);
    send_word(rand_word(), 4'd5, 0);
    send_word(rand_word(), 4'd15, 0);
    send_word('1, 4'd3, 1);
    for (int i = 0; i < 16; i++) send_word(rand_word(), 4'd8, 0);
    send_word(64'd0, 4'd0, 1);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_DIGEST, dig_set[ph]);
      write_reg(REG_KEY, key_set[ph]);
      if (ph == 1) hold_off = 1;
      start = sent;
      while (sent - start < 35) begin
        if (ph == 3 && sent - start > 15 && sent - start < 25) begin
          @(negedge clk);
          s_axis_tvalid <= 0;
          burst_left = 0;
          while (pending != 0) @(negedge clk);
        end
        if ($urandom_range(0, 9) == 0) send_message(key_set[ph] != 0, $urandom_range(17, 34));
        else send_message(key_set[ph] != 0 && $urandom_range(0, 1), $urandom_range(0, 18));
      end
    end

    drain();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
